FILE: rtl/fhs_pkg.sv
// ----------------------------------------------------------------------------
// fhs_pkg
// Shared types and constants of the fronthaul header sequencer.
// ----------------------------------------------------------------------------
package fhs_pkg;

    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    localparam logic [4:0] SYMBOLS_PER_SLOT    = 5'd14;
    localparam logic [4:0] SUBFRAMES_PER_FRAME = 5'd10;
    localparam logic [4:0] MAX_SLOTS           = 5'd16;
    localparam logic [7:0] SEQ_LAST            = 8'd254;
    localparam logic [14:0] PAYLOAD_MAX        = 15'd16383;

    typedef enum logic
    {
        REG_PACKETS_PER_SYMBOL = 1'b0,
        REG_SLOTS_PER_SUBFRAME = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        logic [9:0]  frame_id;
        logic [3:0]  subframe_id;
        logic [3:0]  slot_id;
        logic [3:0]  symbol_id;
        logic [11:0] start_prb;
        logic [8:0]  num_prb;
        logic [13:0] payload_bytes;
        logic [7:0]  seq_id;
    } header_t;

endpackage

FILE: rtl/fhs_counters.sv
// ----------------------------------------------------------------------------
// fhs_counters
// Position counter cascade, sequence counter and PRB offset. Gives the
// header of the packet being advanced and steps the state on advance.
// ----------------------------------------------------------------------------
module fhs_counters
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic [8:0]           rbs,
    input  logic [7:0]           packets_per_symbol,
    input  logic [4:0]           slots_per_subframe,
    output fhs_pkg::header_t     header
);

    logic        started_reg;
    logic [7:0]  pis_reg;
    logic [3:0]  symbol_reg;
    logic [3:0]  slot_reg;
    logic [3:0]  subframe_reg;
    logic [9:0]  frame_reg;
    logic [11:0] prb_reg;
    logic [7:0]  seq_reg;

    logic [7:0]  pis_next;
    logic [3:0]  symbol_next;
    logic [3:0]  slot_next;
    logic [3:0]  subframe_next;
    logic [9:0]  frame_next;
    logic [11:0] prb_next;
    logic [7:0]  seq_next;

    logic [7:0]  pps_eff;
    logic [4:0]  sps_eff;
    logic [8:0]  pis_inc;
    logic [4:0]  symbol_inc;
    logic [4:0]  slot_inc;
    logic [4:0]  subframe_inc;
    logic        wrap_pis;
    logic        wrap_symbol;
    logic        wrap_slot;
    logic        wrap_subframe;
    logic [14:0] payload_full;

    always_comb
    begin
        pps_eff = (packets_per_symbol == 8'd0) ? 8'd1 : packets_per_symbol;
        if (slots_per_subframe == 5'd0)
        begin
            sps_eff = 5'd1;
        end
        else if (slots_per_subframe > fhs_pkg::MAX_SLOTS)
        begin
            sps_eff = fhs_pkg::MAX_SLOTS;
        end
        else
        begin
            sps_eff = slots_per_subframe;
        end

        pis_inc       = started_reg ? ({1'b0, pis_reg} + 9'd1) : 9'd0;
        symbol_inc    = {1'b0, symbol_reg} + 5'd1;
        slot_inc      = {1'b0, slot_reg} + 5'd1;
        subframe_inc  = {1'b0, subframe_reg} + 5'd1;

        wrap_pis      = pis_inc >= {1'b0, pps_eff};
        wrap_symbol   = wrap_pis && (symbol_inc >= fhs_pkg::SYMBOLS_PER_SLOT);
        wrap_slot     = wrap_symbol && (slot_inc >= sps_eff);
        wrap_subframe = wrap_slot && (subframe_inc >= fhs_pkg::SUBFRAMES_PER_FRAME);

        pis_next      = wrap_pis ? 8'd0 : pis_inc[7:0];
        symbol_next   = !wrap_pis ? symbol_reg : (wrap_symbol ? 4'd0 : symbol_inc[3:0]);
        slot_next     = !wrap_symbol ? slot_reg : (wrap_slot ? 4'd0 : slot_inc[3:0]);
        subframe_next = !wrap_slot ? subframe_reg
                                   : (wrap_subframe ? 4'd0 : subframe_inc[3:0]);
        frame_next    = wrap_subframe ? (frame_reg + 10'd1) : frame_reg;

        seq_next      = (seq_reg >= fhs_pkg::SEQ_LAST) ? 8'd0 : (seq_reg + 8'd1);
        prb_next      = (symbol_next == 4'd0) ? 12'd0 : (prb_reg + {3'd0, rbs});

        payload_full  = {1'b0, rbs, 5'd0} + {2'b0, rbs, 4'd0};

        header.frame_id      = frame_next;
        header.subframe_id   = subframe_next;
        header.slot_id       = slot_next;
        header.symbol_id     = symbol_next;
        header.start_prb     = prb_reg;
        header.num_prb       = rbs;
        header.payload_bytes = (payload_full > fhs_pkg::PAYLOAD_MAX)
                               ? fhs_pkg::PAYLOAD_MAX[13:0] : payload_full[13:0];
        header.seq_id        = seq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg  <= 1'b0;
            pis_reg      <= 8'd0;
            symbol_reg   <= 4'd0;
            slot_reg     <= 4'd0;
            subframe_reg <= 4'd0;
            frame_reg    <= 10'd0;
            prb_reg      <= 12'd0;
            seq_reg      <= fhs_pkg::SEQ_LAST;
        end
        else if (advance)
        begin
            started_reg  <= 1'b1;
            pis_reg      <= pis_next;
            symbol_reg   <= symbol_next;
            slot_reg     <= slot_next;
            subframe_reg <= subframe_next;
            frame_reg    <= frame_next;
            prb_reg      <= prb_next;
            seq_reg      <= seq_next;
        end
    end

endmodule

FILE: rtl/fronthaul_header_sequencer.sv
// ----------------------------------------------------------------------------
// fronthaul_header_sequencer
// Generates eCPRI / O-RAN U-plane header fields, one header per request.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-----------------------------------------
//   request  | in_valid/in_stall   | num_rbs
//   header   | out_valid/out_stall | frame_id .. seq_id
//   config   | APB write/read      | packets_per_symbol, slots_per_subframe
//
// One request per cycle is taken while in_stall is low; it passes the request
// register and then the output register before its header can be taken.
// Requests are registered, the header is formed from the counter state in
// one pass and held in the output register until taken.
// Reset clears the position and PRB counters and sets the sequence counter to
// its last value, so the first sequence id is zero. A stalled header holds the
// request register, which then stalls the input.
module fronthaul_header_sequencer
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fhs_pkg::ADDR_W-1:0]  paddr,
    input  logic [fhs_pkg::DATA_W-1:0]  pwdata,
    output logic [fhs_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [8:0]                  num_rbs,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [9:0]                  frame_id,
    output logic [3:0]                  subframe_id,
    output logic [3:0]                  slot_id,
    output logic [3:0]                  symbol_id,
    output logic [11:0]                 start_prb,
    output logic [8:0]                  num_prb,
    output logic [13:0]                 payload_bytes,
    output logic [7:0]                  seq_id
);

    logic [7:0]           pps_reg;
    logic [4:0]           sps_reg;
    logic                 s1_valid_reg;
    logic [8:0]           s1_rbs_reg;
    logic                 out_valid_reg;
    fhs_pkg::header_t     out_reg;
    fhs_pkg::header_t     header;
    fhs_pkg::reg_index_t  reg_sel;
    logic                 cfg_write;
    logic                 out_free;
    logic                 s1_fire;
    logic                 in_accept;

    assign reg_sel   = fhs_pkg::reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb
    begin
        case (reg_sel)
            fhs_pkg::REG_PACKETS_PER_SYMBOL: prdata = {24'd0, pps_reg};
            fhs_pkg::REG_SLOTS_PER_SUBFRAME: prdata = {27'd0, sps_reg};
            default:                         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pps_reg <= 8'd1;
            sps_reg <= 5'd1;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                fhs_pkg::REG_PACKETS_PER_SYMBOL: pps_reg <= pwdata[7:0];
                fhs_pkg::REG_SLOTS_PER_SUBFRAME: sps_reg <= pwdata[4:0];
                default:                         ;
            endcase
        end
    end

    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    fhs_counters u_counters
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .advance            (s1_fire),
        .rbs                (s1_rbs_reg),
        .packets_per_symbol (pps_reg),
        .slots_per_subframe (sps_reg),
        .header             (header)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_rbs_reg <= num_rbs;
        end
        if (s1_fire)
        begin
            out_reg <= header;
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_id      = out_reg.frame_id;
    assign subframe_id   = out_reg.subframe_id;
    assign slot_id       = out_reg.slot_id;
    assign symbol_id     = out_reg.symbol_id;
    assign start_prb     = out_reg.start_prb;
    assign num_prb       = out_reg.num_prb;
    assign payload_bytes = out_reg.payload_bytes;
    assign seq_id        = out_reg.seq_id;

    a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("Input stalled while the pipeline has room.");

    a_seq_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.seq_id != 8'd255))
        else $error("Sequence id out of range.");

    a_symbol_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.symbol_id < 4'd14 && out_reg.subframe_id < 4'd10))
        else $error("Symbol or subframe id out of range.");

    a_fire_loads_output : assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("Header beat lost between stages.");

endmodule
